@@ rtl/core/smpq_pkg.sv @@
// Shared types and constants for the sorted minimum priority queue.
// No dependencies; compile first.
package smpq_pkg;

    localparam int unsigned DEF_CAPACITY = 16;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned COUNT_W      = 5;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } smpq_req_t;

    typedef struct packed
    {
        status_t                  status;
        logic signed [DATA_W-1:0] removed_value;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] smallest;
        logic                     smallest_valid;
    } smpq_rsp_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_PUT,
        ST_REM_LOAD,
        ST_EMIT
    } smpq_state_t;

endpackage

@@ rtl/core/smpq_if.sv @@
// Valid/ready channel interfaces for request and result transfers.
// Depends on smpq_pkg.
interface smpq_req_if import smpq_pkg::*; ();
    logic      valid;
    logic      ready;
    smpq_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface smpq_rsp_if import smpq_pkg::*; ();
    logic      valid;
    logic      ready;
    smpq_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/sorted_min_priority_queue.sv @@
// Sorted minimum priority queue: top level, control and entry memory.
// Depends on smpq_pkg and the channel interfaces in smpq_if.
//
// Holds up to CAPACITY signed 32-bit entries in ascending order in one
// synchronous memory used as a circular buffer, plus a cached minimum.
// A request is taken only while the block is idle; each request gives one
// result. A remove that leaves entries behind passes through a load state
// to fetch the new minimum. An insert into a non-empty queue scans down
// from the tail; each held entry larger than the new value moves up one
// place a cycle through the memory's single read and single write port.
// A full insert or an empty remove goes straight to the result. The result
// sits in an output register, so the next request is taken while it waits.
// The memory needs no clearing after reset.
module sorted_min_priority_queue import smpq_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
)
(
    input logic        clk,
    input logic        rst_n,
    smpq_req_if.sink   req,
    smpq_rsp_if.source rsp
);

    localparam int unsigned PTR_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                              input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(CAPACITY))
        begin
            sum = sum - (PTR_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    logic signed [DATA_W-1:0] mem [CAPACITY];

    smpq_state_t              state_reg, state_next;
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [PTR_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] removed_reg, removed_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    smpq_rsp_t                rsp_data_reg, rsp_data_next;
    logic signed [DATA_W-1:0] rd_data_reg;

    logic                     mem_re;
    logic [PTR_W-1:0]         mem_raddr;
    logic                     mem_we;
    logic [PTR_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;

    logic                     req_xfer;
    logic                     rsp_free;
    logic                     q_full;
    logic                     q_empty;
    logic                     shift_up;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign q_full    = (count_reg == CNT_W'(CAPACITY));
    assign q_empty   = (count_reg == '0);
    assign shift_up  = (rd_data_reg > val_reg);

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req.data.op == OP_INSERT)
                    begin
                        state_next = (q_full || q_empty) ? ST_EMIT : ST_INS_SCAN;
                    end
                    else
                    begin
                        state_next = (count_reg > CNT_W'(1)) ? ST_REM_LOAD : ST_EMIT;
                    end
                end
            end
            ST_INS_SCAN:
            begin
                if (!shift_up)
                begin
                    state_next = ST_EMIT;
                end
                else if (pos_reg == PTR_W'(1))
                begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT:  state_next = ST_EMIT;
            ST_REM_LOAD: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        min_next       = min_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = val_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    status_next  = STATUS_DONE;
                    removed_next = '0;
                    if (req.data.op == OP_INSERT)
                    begin
                        val_next = req.data.value;
                        if (q_full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else if (q_empty)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = head_reg;
                            mem_wdata  = req.data.value;
                            min_next   = req.data.value;
                            count_next = CNT_W'(1);
                        end
                        else
                        begin
                            pos_next  = PTR_W'(count_reg);
                            mem_re    = 1'b1;
                            mem_raddr = phys(head_reg, PTR_W'(count_reg - CNT_W'(1)));
                        end
                    end
                    else
                    begin
                        if (q_empty)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            removed_next = min_reg;
                            head_next    = phys(head_reg, PTR_W'(1));
                            count_next   = count_reg - CNT_W'(1);
                            mem_re       = 1'b1;
                            mem_raddr    = phys(head_reg, PTR_W'(1));
                        end
                    end
                end
            end
            ST_INS_SCAN:
            begin
                // move a larger entry up one place, or drop the new value in its slot
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, pos_reg);
                if (shift_up)
                begin
                    mem_wdata = rd_data_reg;
                    pos_next  = pos_reg - PTR_W'(1);
                    if (pos_reg != PTR_W'(1))
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = phys(head_reg, pos_reg - PTR_W'(2));
                    end
                end
                else
                begin
                    mem_wdata  = val_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_INS_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = head_reg;
                mem_wdata  = val_reg;
                min_next   = val_reg;
                count_next = count_reg + CNT_W'(1);
            end
            ST_REM_LOAD:
            begin
                min_next = rd_data_reg;
            end
            ST_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_data_next.status         = status_reg;
                    rsp_data_next.removed_value  = removed_reg;
                    rsp_data_next.count          = COUNT_W'(count_reg);
                    rsp_data_next.smallest       = q_empty ? '0 : min_reg;
                    rsp_data_next.smallest_valid = !q_empty;
                end
            end
            default:
            begin
                rsp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        min_reg      <= min_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        removed_reg  <= removed_next;
        rsp_data_reg <= rsp_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_xfer_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> state_reg != ST_IDLE)
        else $error("accepted request left the block idle");

    a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INS_SCAN |-> pos_reg != '0)
        else $error("insert scan below the head entry");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && rsp_valid_reg && !rsp.ready) |=> state_reg == ST_EMIT)
        else $error("result dropped while output register busy");
`endif

endmodule

@@ sim/smpq_result_checker.sv @@
// Result checker for the sorted minimum priority queue: watches both channels,
// keeps its own sorted copy of the queue and compares each result transfer.
// Depends on smpq_pkg and the channel interfaces in smpq_if.
module smpq_result_checker import smpq_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
)
(
    input logic clk,
    input logic rst_n,
    smpq_req_if req,
    smpq_rsp_if rsp,
    output int  failures,
    output int  awaited
);

    timeunit 1ns;
    timeprecision 1ps;

    logic signed [DATA_W-1:0] held_values[$];
    smpq_rsp_t                awaited_results[$];
    int                       result_index;

    initial
    begin
        failures     = 0;
        awaited      = 0;
        result_index = 0;
    end

    task automatic note_failure(string msg);
        $display("[%0t] result %0d: %s", $realtime, result_index, msg);
        failures++;
    endtask

    function automatic smpq_rsp_t predict_queue_outcome(smpq_req_t item);
        smpq_rsp_t outcome;
        int        pos;
        outcome        = '0;
        outcome.status = STATUS_DONE;
        if (item.op == OP_INSERT)
        begin
            if (held_values.size() >= CAPACITY)
                outcome.status = STATUS_FULL;
            else
            begin
                pos = held_values.size();
                while (pos > 0 && held_values[pos-1] > item.value)
                    pos--;
                held_values.insert(pos, item.value);
            end
        end
        else
        begin
            if (held_values.size() == 0)
                outcome.status = STATUS_EMPTY;
            else
                outcome.removed_value = held_values.pop_front();
        end
        outcome.count = COUNT_W'(held_values.size());
        if (held_values.size() > 0)
        begin
            outcome.smallest       = held_values[0];
            outcome.smallest_valid = 1'b1;
        end
        return outcome;
    endfunction

    always @(posedge clk)
    begin
        smpq_rsp_t got;
        smpq_rsp_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                awaited_results.push_back(predict_queue_outcome(req.data));
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (awaited_results.size() == 0)
                    note_failure($sformatf("unexpected transfer, status %0d count %0d",
                                           got.status, got.count));
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status)
                        note_failure($sformatf("status %0d, expected %0d",
                                               got.status, want.status));
                    if (got.removed_value !== want.removed_value)
                        note_failure($sformatf("removed_value %0d, expected %0d",
                                               got.removed_value, want.removed_value));
                    if (got.count !== want.count)
                        note_failure($sformatf("count %0d, expected %0d",
                                               got.count, want.count));
                    if (got.smallest !== want.smallest)
                        note_failure($sformatf("smallest %0d, expected %0d",
                                               got.smallest, want.smallest));
                    if (got.smallest_valid !== want.smallest_valid)
                        note_failure($sformatf("smallest_valid %0b, expected %0b",
                                               got.smallest_valid, want.smallest_valid));
                end
                result_index++;
            end
        end
        awaited <= awaited_results.size();
    end

endmodule

@@ sim/sorted_min_priority_queue_test.sv @@
// Top of the sorted minimum priority queue testbench: clock, reset, request
// and result stimulus with idling phases, watchdog and verdict.
// Depends on smpq_pkg, smpq_if, the block and smpq_result_checker.
module sorted_min_priority_queue_test import smpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                       PHASE_ITEMS      = 575;
    localparam int                       BLOCK_ITEMS      = 24;
    localparam int                       LONG_HOLD_CYCLES = 300;
    localparam int                       WATCHDOG_LIMIT   = 3000;
    localparam int                       DRAIN_CYCLES     = 40;
    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE    = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POSITIVE    = {1'b0, {(DATA_W-1){1'b1}}};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   tx_idle_pct       = 6;
    int   rx_stall_pct      = 69;
    logic long_hold_pending = 1'b0;
    int   failures;
    int   awaited;
    int   quiet_cycles;

    smpq_req_if req_ch ();
    smpq_rsp_if rsp_ch ();

    sorted_min_priority_queue #(
        .CAPACITY (DEF_CAPACITY)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    smpq_result_checker #(
        .CAPACITY (DEF_CAPACITY)
    ) i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .failures (failures),
        .awaited  (awaited)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return MOST_NEGATIVE;
            1: return MOST_POSITIVE;
            2, 3, 4: return $signed(DATA_W'($urandom_range(16))) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic transfer_request(op_t op, logic signed [DATA_W-1:0] value);
        int gap;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            gap = 1;
            while ($urandom_range(99) < tx_idle_pct)
                gap++;
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= '{op: op, value: value};
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic random_requests(int total);
        int insert_pct;
        insert_pct = 50;
        for (int i = 0; i < total; i++)
        begin
            if (i % BLOCK_ITEMS == 0)
            begin
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            transfer_request(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                             pick_value());
        end
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty remove, extremes, duplicates, then fill to capacity and overflow
        transfer_request(OP_REMOVE, MOST_POSITIVE);
        transfer_request(OP_INSERT, MOST_POSITIVE);
        transfer_request(OP_INSERT, MOST_NEGATIVE);
        transfer_request(OP_INSERT, 0);
        transfer_request(OP_INSERT, -1);
        transfer_request(OP_INSERT, 1);
        transfer_request(OP_INSERT, 0);
        transfer_request(OP_INSERT, MOST_POSITIVE);
        transfer_request(OP_INSERT, MOST_NEGATIVE);
        transfer_request(OP_REMOVE, MOST_NEGATIVE);
        transfer_request(OP_REMOVE, 0);
        transfer_request(OP_REMOVE, -1);
        for (int i = 0; i < 11; i++)
            transfer_request(OP_INSERT, (i % 2) ? -(1 <<< (i * 3)) : (1 <<< (i * 3)));
        transfer_request(OP_INSERT, -7);

        random_requests(PHASE_ITEMS);

        tx_idle_pct  = 69;
        rx_stall_pct = 6;
        random_requests(PHASE_ITEMS);

        // hold the result side off while inserts keep arriving
        tx_idle_pct       = 0;
        rx_stall_pct      = 0;
        long_hold_pending = 1'b1;
        for (int i = 0; i < BLOCK_ITEMS; i++)
            transfer_request(OP_INSERT, pick_value());
        random_requests(PHASE_ITEMS - BLOCK_ITEMS);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/smpq_pkg.sv
rtl/core/smpq_if.sv
rtl/core/sorted_min_priority_queue.sv
sim/smpq_result_checker.sv
sim/sorted_min_priority_queue_test.sv
